[hdl/qlcm_pkg.sv]
package qlcm_pkg;

    // table geometry and number formats
    localparam int DIM        = 17;
    localparam int FRAC_BITS  = 4;
    localparam int ENTRY_BITS = 16;

    localparam int NCHAN    = 3;
    localparam int NCORNER  = 16;
    localparam int GRID_SIZE = DIM * DIM * DIM * DIM;
    localparam int IDX_W    = 17;
    localparam int COORD_W  = $clog2(DIM);
    localparam int FRAC_W   = FRAC_BITS + 1;
    localparam int ONE_FRAC = 1 << FRAC_BITS;
    localparam int PAIR_W   = 2 * FRAC_BITS + 1;
    localparam int WT_W     = 4 * FRAC_BITS + 1;

    // corner-parity banking: each bank holds one parity class of the grid
    localparam int HALF_DIM   = (DIM + 1) / 2;
    localparam int BANK_DEPTH = HALF_DIM * HALF_DIM * HALF_DIM * HALF_DIM;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // index split by reciprocal multiplication
    localparam int RECIP_SH = 24;
    localparam int RECIP    = (1 << RECIP_SH) / DIM;
    localparam int RECIP_W  = $clog2(RECIP + 1);

    // accumulation widths
    localparam int PROD_W    = ENTRY_BITS + WT_W + 1;
    localparam int SUM_W     = PROD_W + 4;
    localparam int SUM_SHIFT = 4 * FRAC_BITS;

    // queue depths
    localparam int MID_DEPTH = 16;
    localparam int OUT_DEPTH = 8;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_PIXEL = 1'b1
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [7:0]         context_value;
        logic [7:0]         red_value;
        logic [7:0]         green_value;
        logic [7:0]         blue_value;
        logic               frame_end;
        logic [1:0]         entry_channel;
        logic [16:0]        entry_index;
        logic signed [15:0] entry_value;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_first;
        logic signed [15:0] out_second;
        logic signed [15:0] out_third;
        logic               frame_last;
    } out_t;

    // front pipeline word
    typedef struct packed {
        logic                          pix;
        logic                          last;
        logic                          ok;
        logic [1:0]                    chan;
        logic signed [ENTRY_BITS-1:0]  val;
        logic [IDX_W-1:0]              rem;
        logic [3:0][COORD_W-1:0]       crd;
        logic [3:0][FRAC_W-1:0]        frac;
    } fe_t;

    // word passed from front to back through the middle queue
    typedef struct packed {
        logic                              pix;
        logic                              last;
        logic                              wr;
        logic [1:0]                        chan;
        logic signed [ENTRY_BITS-1:0]      val;
        logic [3:0]                        wbank;
        logic [NCORNER-1:0][BANK_AW-1:0]   raddr;
        logic [NCORNER-1:0][WT_W-1:0]      wt;
    } mid_t;

endpackage

[hdl/qlcm_fifo.sv]
module qlcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic             full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == CW'(0));
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[hdl/qlcm_front.sv]
module qlcm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  qlcm_pkg::in_t     in_word,
    output logic              out_valid,
    output qlcm_pkg::mid_t    out_word
);

    localparam int VAL_MAX = (1 << (qlcm_pkg::ENTRY_BITS - 1)) - 1;
    localparam int VAL_MIN = -(1 << (qlcm_pkg::ENTRY_BITS - 1));
    localparam int MW      = qlcm_pkg::IDX_W + qlcm_pkg::RECIP_W;
    localparam int NST     = 9;

    qlcm_pkg::fe_t st_reg [7];
    qlcm_pkg::fe_t s0_next;
    qlcm_pkg::fe_t w1_reg;
    logic [qlcm_pkg::IDX_W-1:0]  q_reg [3];
    logic [qlcm_pkg::PAIR_W-1:0] lo_reg [4];
    logic [qlcm_pkg::PAIR_W-1:0] hi_reg [4];
    logic [qlcm_pkg::PAIR_W-1:0] lo_next [4];
    logic [qlcm_pkg::PAIR_W-1:0] hi_next [4];
    qlcm_pkg::mid_t mid_reg, mid_next;
    logic [NST-1:0] v_reg;
    logic [3:0][7:0] comp;

    // quotient estimate from the reciprocal, low by at most one
    function automatic logic [qlcm_pkg::IDX_W-1:0] q_est(input logic [qlcm_pkg::IDX_W-1:0] r);
        logic [MW-1:0] p;
        p = MW'(r) * MW'(qlcm_pkg::RECIP);
        return qlcm_pkg::IDX_W'(p >> qlcm_pkg::RECIP_SH);
    endfunction

    // correct the estimate and peel off one grid digit
    function automatic qlcm_pkg::fe_t div_fix(input qlcm_pkg::fe_t s,
                                              input logic [qlcm_pkg::IDX_W-1:0] q_in,
                                              input int j);
        qlcm_pkg::fe_t t;
        logic [qlcm_pkg::IDX_W-1:0] q;
        logic [qlcm_pkg::IDX_W-1:0] rest;
        t    = s;
        q    = q_in;
        rest = s.rem - qlcm_pkg::IDX_W'(q_in * qlcm_pkg::IDX_W'(qlcm_pkg::DIM));
        if (rest >= qlcm_pkg::IDX_W'(qlcm_pkg::DIM))
        begin
            rest = rest - qlcm_pkg::IDX_W'(qlcm_pkg::DIM);
            q    = q + 1'b1;
        end
        if (!s.pix)
        begin
            t.crd[j] = qlcm_pkg::COORD_W'(rest);
            t.rem    = q;
            if (j == 2)
            begin
                t.crd[3] = qlcm_pkg::COORD_W'(q);
            end
        end
        return t;
    endfunction

    // per-axis weight: fraction for the upper corner, its complement below
    function automatic logic [qlcm_pkg::FRAC_W-1:0] fsel(input logic [qlcm_pkg::FRAC_W-1:0] f,
                                                         input logic up);
        return up ? f : qlcm_pkg::FRAC_W'(qlcm_pkg::ONE_FRAC) - f;
    endfunction

    assign comp = {in_word.blue_value, in_word.green_value,
                   in_word.red_value, in_word.context_value};

    // classify the word: split pixel components, range check and clamp entries
    always_comb
    begin
        int ev;
        logic [7:0] ci;
        s0_next       = '0;
        s0_next.pix   = (in_word.func == qlcm_pkg::FUNC_PIXEL);
        s0_next.last  = in_word.frame_end;
        s0_next.chan  = in_word.entry_channel;
        s0_next.rem   = in_word.entry_index;
        s0_next.ok    = (in_word.entry_channel < 2'(qlcm_pkg::NCHAN)) &&
                        ({15'b0, in_word.entry_index} < 32'(qlcm_pkg::GRID_SIZE));
        ev = 32'(in_word.entry_value);
        if (ev > VAL_MAX)
        begin
            ev = VAL_MAX;
        end
        else if (ev < VAL_MIN)
        begin
            ev = VAL_MIN;
        end
        s0_next.val = qlcm_pkg::ENTRY_BITS'(ev);
        for (int a = 0; a < 4; a++)
        begin
            ci = comp[a] >> qlcm_pkg::FRAC_BITS;
            if (ci >= 8'(qlcm_pkg::DIM - 1))
            begin
                s0_next.crd[a]  = qlcm_pkg::COORD_W'(qlcm_pkg::DIM - 2);
                s0_next.frac[a] = qlcm_pkg::FRAC_W'(qlcm_pkg::ONE_FRAC);
            end
            else
            begin
                s0_next.crd[a]  = qlcm_pkg::COORD_W'(ci);
                s0_next.frac[a] = qlcm_pkg::FRAC_W'(comp[a] & 8'(qlcm_pkg::ONE_FRAC - 1));
            end
        end
    end

    // pair weights for the two lower axes and the two upper axes
    always_comb
    begin
        logic [1:0] kk;
        for (int i = 0; i < 4; i++)
        begin
            kk = 2'(i);
            lo_next[i] = qlcm_pkg::PAIR_W'(fsel(st_reg[6].frac[0], kk[0])) *
                         qlcm_pkg::PAIR_W'(fsel(st_reg[6].frac[1], kk[1]));
            hi_next[i] = qlcm_pkg::PAIR_W'(fsel(st_reg[6].frac[2], kk[0])) *
                         qlcm_pkg::PAIR_W'(fsel(st_reg[6].frac[3], kk[1]));
        end
    end

    // full weights and per-bank addresses, ordered by bank
    always_comb
    begin
        logic [3:0] lb;
        logic [3:0] k;
        logic [3:0][qlcm_pkg::COORD_W-1:0] h;
        mid_next       = '0;
        mid_next.pix   = w1_reg.pix;
        mid_next.last  = w1_reg.last;
        mid_next.wr    = !w1_reg.pix && w1_reg.ok;
        mid_next.chan  = w1_reg.chan;
        mid_next.val   = w1_reg.val;
        for (int a = 0; a < 4; a++)
        begin
            lb[a] = w1_reg.crd[a][0];
        end
        mid_next.wbank = lb;
        for (int b = 0; b < qlcm_pkg::NCORNER; b++)
        begin
            k = 4'(b) ^ lb;
            mid_next.wt[b] = qlcm_pkg::WT_W'(lo_reg[k[1:0]]) * qlcm_pkg::WT_W'(hi_reg[k[3:2]]);
            for (int a = 0; a < 4; a++)
            begin
                h[a] = qlcm_pkg::COORD_W'(((qlcm_pkg::COORD_W + 1)'(w1_reg.crd[a]) +
                                           (qlcm_pkg::COORD_W + 1)'(k[a])) >> 1);
            end
            mid_next.raddr[b] = qlcm_pkg::BANK_AW'(
                ((32'(h[3]) * qlcm_pkg::HALF_DIM + 32'(h[2])) * qlcm_pkg::HALF_DIM
                 + 32'(h[1])) * qlcm_pkg::HALF_DIM + 32'(h[0]));
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        st_reg[0] <= s0_next;
        for (int j = 0; j < 3; j++)
        begin
            q_reg[j]        <= q_est(st_reg[2 * j].rem);
            st_reg[2 * j + 1] <= st_reg[2 * j];
            st_reg[2 * j + 2] <= div_fix(st_reg[2 * j + 1], q_reg[j], j);
        end
        w1_reg <= st_reg[6];
        for (int i = 0; i < 4; i++)
        begin
            lo_reg[i] <= lo_next[i];
            hi_reg[i] <= hi_next[i];
        end
        mid_reg <= mid_next;
    end

    assign out_valid = v_reg[NST-1];
    assign out_word  = mid_reg;

endmodule

[hdl/qlcm_back.sv]
module qlcm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mid_valid,
    input  qlcm_pkg::mid_t    mid_word,
    output logic              mid_pop,
    output logic              empty,
    input  logic              pop,
    output qlcm_pkg::out_t    result
);

    localparam int CW   = $clog2(qlcm_pkg::OUT_DEPTH + 1);
    localparam int PW   = qlcm_pkg::PROD_W + 2;
    localparam int SW   = qlcm_pkg::SUM_W;
    localparam int EB   = qlcm_pkg::ENTRY_BITS;
    localparam logic signed [SW-1:0] HALF_LSB = SW'(1) << (qlcm_pkg::SUM_SHIFT - 1);
    localparam logic signed [SW-1:0] OUT_MAX  = SW'(32767);
    localparam logic signed [SW-1:0] OUT_MIN  = -SW'(32768);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          we;
    logic [qlcm_pkg::BANK_AW-1:0] waddr;
    logic          res_pop;

    logic signed [EB-1:0] rdata [qlcm_pkg::NCHAN][qlcm_pkg::NCORNER];
    logic [qlcm_pkg::NCORNER-1:0][qlcm_pkg::WT_W-1:0] wt1_reg;
    logic signed [qlcm_pkg::PROD_W-1:0] prod_reg [qlcm_pkg::NCHAN][qlcm_pkg::NCORNER];
    logic signed [PW-1:0] part_reg [qlcm_pkg::NCHAN][4];
    logic signed [SW-1:0] sum_reg [qlcm_pkg::NCHAN];
    logic [5:1] v_reg;
    logic [5:1] last_reg;
    logic signed [15:0] chan_res [qlcm_pkg::NCHAN];
    qlcm_pkg::out_t res_reg, res_next;
    logic out_full;

    // take any write from the middle queue, and a pixel when the result queue can absorb it
    assign mid_pop = mid_valid &&
                     (!mid_word.pix || (cnt_reg < CW'(qlcm_pkg::OUT_DEPTH)));
    assign we      = mid_pop && mid_word.wr;
    assign waddr   = mid_word.raddr[mid_word.wbank];
    assign res_pop = pop && !empty;

    // result queue credit: pixels in the back pipeline plus waiting results
    always_comb
    begin
        cnt_next = cnt_reg;
        if ((mid_pop && mid_word.pix) && !res_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!(mid_pop && mid_word.pix) && res_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // table banks, one per channel and corner parity
    for (genvar c = 0; c < qlcm_pkg::NCHAN; c++)
    begin : g_chan
        for (genvar b = 0; b < qlcm_pkg::NCORNER; b++)
        begin : g_bank
            logic signed [EB-1:0] mem [qlcm_pkg::BANK_DEPTH];
            logic signed [EB-1:0] rd_reg;
            always_ff @(posedge clk)
            begin
                if (we && (mid_word.wbank == 4'(b)) && (mid_word.chan == 2'(c)))
                begin
                    mem[waddr] <= mid_word.val;
                end
                rd_reg <= mem[mid_word.raddr[b]];
            end
            assign rdata[c][b] = rd_reg;
        end
    end

    // round to nearest, return to entry format and saturate
    always_comb
    begin
        logic signed [SW-1:0] rs;
        for (int c = 0; c < qlcm_pkg::NCHAN; c++)
        begin
            rs = (sum_reg[c] + HALF_LSB) >>> qlcm_pkg::SUM_SHIFT;
            if (rs > OUT_MAX)
            begin
                chan_res[c] = 16'sh7fff;
            end
            else if (rs < OUT_MIN)
            begin
                chan_res[c] = -16'sh8000;
            end
            else
            begin
                chan_res[c] = 16'(rs);
            end
        end
        res_next.out_first  = chan_res[0];
        res_next.out_second = chan_res[1];
        res_next.out_third  = chan_res[2];
        res_next.frame_last = last_reg[4];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v_reg   <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            v_reg   <= {v_reg[4:1], mid_pop && mid_word.pix};
        end
    end

    // weighting and accumulation stages
    always_ff @(posedge clk)
    begin
        wt1_reg     <= mid_word.wt;
        last_reg    <= {last_reg[4:1], mid_word.last};
        for (int c = 0; c < qlcm_pkg::NCHAN; c++)
        begin
            for (int b = 0; b < qlcm_pkg::NCORNER; b++)
            begin
                prod_reg[c][b] <= qlcm_pkg::PROD_W'(rdata[c][b]) *
                                  qlcm_pkg::PROD_W'(signed'({1'b0, wt1_reg[b]}));
            end
            for (int g = 0; g < 4; g++)
            begin
                part_reg[c][g] <= PW'(prod_reg[c][4 * g]) + PW'(prod_reg[c][4 * g + 1]) +
                                  PW'(prod_reg[c][4 * g + 2]) + PW'(prod_reg[c][4 * g + 3]);
            end
            sum_reg[c] <= SW'(part_reg[c][0]) + SW'(part_reg[c][1]) +
                          SW'(part_reg[c][2]) + SW'(part_reg[c][3]);
        end
        res_reg <= res_next;
    end

    // waiting results
    qlcm_fifo #(
        .WIDTH($bits(qlcm_pkg::out_t)),
        .DEPTH(qlcm_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (v_reg[5]),
        .din   (res_reg),
        .pop   (pop),
        .dout  (result),
        .empty (empty),
        .full  (out_full)
    );

    logic unused_full;
    assign unused_full = out_full;

endmodule

[hdl/quadrilinear_lut_color_map.sv]
// 4D color lookup with quadrilinear interpolation over three output channels.
// Words with func = write fill one table entry; words with func = pixel give
// one result word, in order. The block takes one word every clock when the
// result side keeps up; a pixel passes 9 front stages, the middle queue and
// 6 back stages, the last of which writes its result into the result queue.
// The one-per-clock figure comes from the table being split into 16 banks by
// grid-corner parity per channel, so all 16 corners of a pixel are read in the
// same cycle. A table entry must be written before any pixel that reads it; a
// write becomes visible to the next word.
module quadrilinear_lut_color_map (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  qlcm_pkg::in_t   item,
    output logic            empty,
    input  logic            pop,
    output qlcm_pkg::out_t  result
);

    localparam int FCW = $clog2(qlcm_pkg::MID_DEPTH + 1);

    logic           accept;
    logic           front_valid;
    qlcm_pkg::mid_t front_word;
    qlcm_pkg::mid_t mid_word;
    logic           mid_empty, mid_full, mid_pop;
    logic [FCW-1:0] front_cnt_reg, front_cnt_next;

    // credit for the middle queue covers words in the front pipeline too
    assign full   = (front_cnt_reg == FCW'(qlcm_pkg::MID_DEPTH));
    assign accept = push && !full;

    always_comb
    begin
        front_cnt_next = front_cnt_reg;
        if (accept && !mid_pop)
        begin
            front_cnt_next = front_cnt_reg + 1'b1;
        end
        else if (!accept && mid_pop)
        begin
            front_cnt_next = front_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cnt_reg <= '0;
        end
        else
        begin
            front_cnt_reg <= front_cnt_next;
        end
    end

    qlcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_word   (item),
        .out_valid (front_valid),
        .out_word  (front_word)
    );

    qlcm_fifo #(
        .WIDTH($bits(qlcm_pkg::mid_t)),
        .DEPTH(qlcm_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .din   (front_word),
        .pop   (mid_pop),
        .dout  (mid_word),
        .empty (mid_empty),
        .full  (mid_full)
    );

    qlcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (!mid_empty),
        .mid_word  (mid_word),
        .mid_pop   (mid_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

`ifndef SYNTHESIS
    // front never delivers a word the middle queue cannot hold
    assert property (@(posedge clk) disable iff (!rst_n) front_valid |-> !mid_full)
        else $error("middle queue overflow");

    // back only takes words that are there
    assert property (@(posedge clk) disable iff (!rst_n) mid_pop |-> !mid_empty)
        else $error("middle queue underflow");

    // credit stays within the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
                     front_cnt_reg <= FCW'(qlcm_pkg::MID_DEPTH))
        else $error("front credit out of range");
`endif

endmodule
